// ----- rtl/core/fsub_pkg.sv -----
`timescale 1ns / 1ps

package fsub_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 5;
  localparam int OFF_W     = 16;
  localparam int CFG_DW    = 64;
  localparam int CFG_AW    = 2;
  localparam int KEY_BYTES = 16;
  localparam int KEY_IDX_W = 4;

  typedef enum logic [CFG_AW-1:0] {
    REG_KEY_LENGTH = 2'd0,
    REG_KEY_LOW    = 2'd1,
    REG_KEY_HIGH   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic             not_found;
    logic [OFF_W-1:0] offset;
  } result_t;

  // per-cell compare setup
  typedef struct packed {
    logic              in_use;
    logic [BYTE_W-1:0] key_byte;
  } cell_cfg_t;

endpackage

// ----- rtl/core/fsub_cell.sv -----
`timescale 1ns / 1ps

module fsub_cell (
  input  logic                             clk_i,
  input  logic                             shift_i,
  input  fsub_pkg::cell_cfg_t              cfg_i,
  input  logic [fsub_pkg::BYTE_W-1:0]      byte_i,
  output logic [fsub_pkg::BYTE_W-1:0]      byte_o,
  output logic                             eq_o
);

  logic [fsub_pkg::BYTE_W-1:0] byte_q, byte_d;

  // compare the byte this cell takes on the current beat
  assign eq_o   = !cfg_i.in_use || (byte_i == cfg_i.key_byte);
  assign byte_d = shift_i ? byte_i : byte_q;
  assign byte_o = byte_q;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

// ----- rtl/core/fsub_out_buf.sv -----
`timescale 1ns / 1ps

module fsub_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fsub_pkg::result_t   res_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                ready_i,
  output fsub_pkg::result_t   res_o
);

  logic              out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  fsub_pkg::result_t out_q, out_d, skid_q, skid_d;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (!out_vld_q || ready_i) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = push_i;
        skid_d     = res_i;
      end else begin
        out_vld_d = push_i;
        out_d     = res_i;
      end
    end else if (push_i) begin
      skid_vld_d = 1'b1;
      skid_d     = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_vld_q;
  assign valid_o = out_vld_q;
  assign res_o   = out_q;

endmodule

// ----- rtl/core/first_substring_match_top.sv -----
`timescale 1ns / 1ps
// First substring match. Text enters on the s_axis channel, one beat per
// clock while the output buffer has room: tdata carries the byte, tuser
// says whether the byte is present, tlast ends the text. Each present
// byte shifts into a row of MAX_KEY_BYTES cells; every cell compares its
// incoming byte with the key byte aligned to it, so a whole key compare
// finishes in the cycle the byte is accepted. Throughput is one beat per
// cycle when not stalled. One result per text is pushed into the output
// buffer on the tlast beat and leaves on m_axis from there: tuser is 1
// for not found, tdata the offset of the first match (0 if none). Keys
// are loaded over the cfg channel (index 0 length, 1 bytes 0-7, 2 bytes
// 8-15); the user must load them only while the block is idle, which it
// does not enforce; cfg_ready_o is always high. A two-entry output buffer
// holds results while m_axis stalls; s_axis keeps taking beats until both
// entries are full. Reset clears the key registers, the byte count, the
// match state and the output buffer; the block is ready as soon as reset
// is released. Bytes past the first MAX_TEXT_BYTES still shift in but are
// not compared, so a match that ends beyond that point is not reported.

module first_substring_match_top #(
  parameter int              MAX_KEY_BYTES  = 16,
  parameter longint unsigned MAX_TEXT_BYTES = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fsub_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [fsub_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [fsub_pkg::BYTE_W-1:0]   s_axis_tdata_i,   // text_byte
  input  logic                          s_axis_tuser_i,   // byte_present
  input  logic                          s_axis_tlast_i,   // end_of_text
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [fsub_pkg::OFF_W-1:0]    m_axis_tdata_o,   // match_offset
  output logic                          m_axis_tuser_o    // status
);

  localparam int CNT_W = $clog2(MAX_TEXT_BYTES + 1);
  localparam int CMP_W = (CNT_W + 1 > fsub_pkg::LEN_W) ? CNT_W + 1 : fsub_pkg::LEN_W;
  localparam int KW    = fsub_pkg::BYTE_W;

  logic [fsub_pkg::LEN_W-1:0]  len_q, len_d;
  logic [fsub_pkg::CFG_DW-1:0] key_lo_q, key_lo_d, key_hi_q, key_hi_d;
  logic [2*fsub_pkg::CFG_DW-1:0] key_all;

  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       seen_q, seen_d;
  logic [fsub_pkg::OFF_W-1:0] start_q, start_d;

  logic                       accept, shift, sat, len_ok, reached, hit, buf_full;
  logic [MAX_KEY_BYTES-1:0]   eq;
  logic [KW-1:0]              win [MAX_KEY_BYTES];
  logic [fsub_pkg::OFF_W-1:0] new_start;
  fsub_pkg::result_t          res, res_out;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    len_d    = len_q;
    key_lo_d = key_lo_q;
    key_hi_d = key_hi_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        fsub_pkg::REG_KEY_LENGTH: len_d    = cfg_data_i[fsub_pkg::LEN_W-1:0];
        fsub_pkg::REG_KEY_LOW:    key_lo_d = cfg_data_i;
        fsub_pkg::REG_KEY_HIGH:   key_hi_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  assign key_all = {key_hi_q, key_lo_q};

  // cell row
  assign s_axis_tready_o = !buf_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign shift           = accept && s_axis_tuser_i;

  for (genvar j = 0; j < MAX_KEY_BYTES; j++) begin : g_cell
    fsub_pkg::cell_cfg_t             ccfg;
    logic [fsub_pkg::KEY_IDX_W-1:0]  kidx;
    logic [fsub_pkg::LEN_W-1:0]      kpos;
    logic [KW-1:0]                   din;

    assign kpos          = len_q - fsub_pkg::LEN_W'(1) - fsub_pkg::LEN_W'(j);
    assign kidx          = kpos[fsub_pkg::KEY_IDX_W-1:0];
    assign ccfg.in_use   = fsub_pkg::LEN_W'(j) < len_q;
    assign ccfg.key_byte = key_all[kidx*KW +: KW];

    if (j == 0) begin : g_head
      assign din = s_axis_tdata_i;
    end else begin : g_link
      assign din = win[j-1];
    end

    fsub_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .cfg_i   (ccfg),
      .byte_i  (din),
      .byte_o  (win[j]),
      .eq_o    (eq[j])
    );
  end

  assign hit       = &eq;
  assign sat       = cnt_q >= CNT_W'(MAX_TEXT_BYTES);
  assign len_ok    = (len_q != '0) && (len_q <= fsub_pkg::LEN_W'(MAX_KEY_BYTES));
  assign reached   = (CMP_W'(cnt_q) + CMP_W'(1)) >= CMP_W'(len_q);
  assign new_start = fsub_pkg::OFF_W'(cnt_q) + fsub_pkg::OFF_W'(1)
                   - fsub_pkg::OFF_W'(len_q);

  always_comb begin
    cnt_d   = cnt_q;
    seen_d  = seen_q;
    start_d = start_q;
    if (shift && !sat) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (!seen_q && len_ok && reached && hit) begin
        seen_d  = 1'b1;
        start_d = new_start;
      end
    end
    res.not_found = !seen_d;
    res.offset    = seen_d ? start_d : '0;
    if (accept && s_axis_tlast_i) begin
      cnt_d   = '0;
      seen_d  = 1'b0;
      start_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      key_lo_q <= '0;
      key_hi_q <= '0;
      cnt_q    <= '0;
      seen_q   <= 1'b0;
      start_q  <= '0;
    end else begin
      len_q    <= len_d;
      key_lo_q <= key_lo_d;
      key_hi_q <= key_hi_d;
      cnt_q    <= cnt_d;
      seen_q   <= seen_d;
      start_q  <= start_d;
    end
  end

  fsub_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && s_axis_tlast_i),
    .res_i   (res),
    .full_o  (buf_full),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res_out)
  );

  assign m_axis_tdata_o = res_out.offset;
  assign m_axis_tuser_o = res_out.not_found;

endmodule

// ----- rtl/core/fsub_checker.sv -----
`timescale 1ns / 1ps

module fsub_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic                        s_axis_tlast_i,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [fsub_pkg::OFF_W-1:0]  m_axis_tdata_o,
  input logic                        m_axis_tuser_o
);

  logic s_beat;
  assign s_beat = s_axis_tvalid_i && s_axis_tready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("nonzero offset on not-found result");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o && s_beat && s_axis_tlast_i |=> m_axis_tvalid_o)
    else $error("no result after end beat");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o && !(s_beat && s_axis_tlast_i) |=> !m_axis_tvalid_o)
    else $error("result without end beat");

endmodule

bind first_substring_match_top fsub_checker u_fsub_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
